// File: design/assert_macros.svh
// Assertion helpers shared by the RTL. Both expect clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define BAR_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define BAR_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bar_pkg.sv
// ----------------------------------------------------------------------------
// Bond alignment rotation package
// Widths, status codes and shared constants of the rotation pipeline.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package bar_pkg;

  // Coordinates and bond vectors
  localparam int COORD_WIDTH   = 32;
  localparam int NUM_IN        = 12;
  localparam int DIFF_W        = COORD_WIDTH + 1;
  localparam int MAG_W         = DIFF_W;
  localparam int SH_W          = 6;

  // Normalized magnitudes and their sum of squares
  localparam int NORM_BITS     = 30;
  localparam int SUMSQ_W       = 2 * NORM_BITS + 2;
  localparam int ROOT_W        = SUMSQ_W / 2;

  // Output format
  localparam int OUT_FRAC_BITS = 30;
  localparam int OUT_W         = 32;
  localparam int NUM_ROT       = 9;

  // Unit components, products and accumulations
  localparam int UNIT_W        = OUT_FRAC_BITS + 2;
  localparam int PROD_W        = 2 * UNIT_W;
  localparam int ACC_W         = PROD_W + 2;

  // Divider widths: 64-bit dividend, 33-bit divisor, 34 quotient bits
  localparam int DVD_W         = PROD_W;
  localparam int DVS_W         = UNIT_W + 1;
  localparam int QUO_W         = 34;

  // Final sum before saturation
  localparam int E_W           = QUO_W + 3;

  // Diagonal positions of the row-major 3x3 matrix
  localparam logic [NUM_ROT-1:0] DIAG_MASK = 9'b100010001;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_ZERO = 2'd1,
    ST_ANTI = 2'd2
  } status_t;

endpackage

`default_nettype wire

// File: design/bond_alignment_rotation_matrix.sv
// ----------------------------------------------------------------------------
// Bond alignment rotation matrix
// Rotation that turns the material bond direction onto the spatial one.
// ----------------------------------------------------------------------------
// Each request carries the Q16.16 positions of atoms i and j in the material
// and spatial configurations; the response is the row-major 3x3 rotation in
// Q1.30 plus a status (ok, zero-length bond, antiparallel bonds; identity
// matrix whenever status is not ok). The block is a 114-stage pipeline: one
// request is taken every cycle unless a response is stalled at the output.
// Most stages belong to the two bit-per-stage units, the 31-stage square root of
// the bond length and the two 34-stage divider banks (unit vectors, then the
// a*a^T/(1+c) term). The whole pipeline advances together, so a stalled
// response holds every stage; s_axis_tready is m_axis_tready or an empty output.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bond_alignment_rotation_matrix (
  input  logic                                      clk,
  input  logic                                      rst,
  // mat_i_x, mat_i_y, mat_i_z, mat_j_x, mat_j_y, mat_j_z,
  // spa_i_x, spa_i_y, spa_i_z, spa_j_x, spa_j_y, spa_j_z (32 bits each)
  input  logic [bar_pkg::NUM_IN*bar_pkg::COORD_WIDTH-1:0] s_axis_tdata,
  input  logic                                      s_axis_tvalid,
  output logic                                      s_axis_tready,
  // rot_00, rot_01, rot_02, rot_10, rot_11, rot_12, rot_20, rot_21, rot_22
  output logic [bar_pkg::NUM_ROT*bar_pkg::OUT_W-1:0] m_axis_tdata,
  // status
  output logic [1:0]                                m_axis_tuser,
  output logic                                      m_axis_tvalid,
  input  logic                                      m_axis_tready
);
  import bar_pkg::*;

  localparam int LAT = 114;
  localparam int SIDE_DLY = ROOT_W + 2;
  localparam int FLG_DLY = QUO_W;
  localparam int FIN_DLY = QUO_W;
  localparam int K_W = DVS_W;

  localparam logic [SH_W-1:0]         NORM_TOP = SH_W'(NORM_BITS - 1);
  localparam logic signed [K_W-1:0]   K_ONE    = K_W'(1) <<< OUT_FRAC_BITS;
  localparam logic [OUT_W-1:0]        OUT_ONE  = OUT_W'(1) << OUT_FRAC_BITS;
  localparam logic signed [E_W-1:0]   E_MAX    =
    {{(E_W-OUT_W+1){1'b0}}, {(OUT_W-1){1'b1}}};
  localparam logic signed [E_W-1:0]   E_MIN    = ~E_MAX;

  typedef struct packed {
    logic [1:0][2:0][NORM_BITS-1:0] nm;
    logic [1:0][2:0]                neg;
    logic                           zero;
  } side_t;

  typedef struct packed {
    logic [1:0][2:0] neg;
    logic            zero;
  } flg_t;

  typedef struct packed {
    logic [UNIT_W-1:0]      c;
    logic [2:0][UNIT_W-1:0] a;
    logic [5:0]             psign;
    status_t                st;
    logic                   ident;
  } fin_t;

  // Position of the highest set bit
  function automatic logic [SH_W-1:0] msb_pos(input logic [MAG_W-1:0] x);
    logic [SH_W-1:0] p;
    p = '0;
    for (int b = 0; b < MAG_W; b++) begin
      if (x[b]) p = SH_W'(b);
    end
    return p;
  endfunction

  // Divide by 2^OUT_FRAC_BITS, truncating toward zero
  function automatic logic signed [UNIT_W-1:0] shr_trunc(input logic signed [ACC_W-1:0] x);
    logic [ACC_W-1:0] m;
    logic [ACC_W-1:0] s;
    m = x[ACC_W-1] ? ACC_W'(-x) : ACC_W'(x);
    s = m >> OUT_FRAC_BITS;
    return x[ACC_W-1] ? UNIT_W'(-s) : UNIT_W'(s);
  endfunction

  // Clamp to the output range
  function automatic logic [OUT_W-1:0] sat(input logic signed [E_W-1:0] x);
    logic signed [E_W-1:0] y;
    y = x;
    if (x > E_MAX) y = E_MAX;
    if (x < E_MIN) y = E_MIN;
    return OUT_W'(y);
  endfunction

  // Global advance: the pipeline moves when the output slot is free or taken
  logic            adv;
  logic [LAT:1]    vld;

  assign adv           = !vld[LAT] || m_axis_tready;
  assign s_axis_tready = adv;
  assign m_axis_tvalid = vld[LAT];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAT-1:1], s_axis_tvalid};
    end
  end

  // Unpack the request
  logic signed [COORD_WIDTH-1:0] in_f [NUM_IN];
  always_comb begin
    for (int f = 0; f < NUM_IN; f++) begin
      in_f[f] = s_axis_tdata[f*COORD_WIDTH +: COORD_WIDTH];
    end
  end

  // Stage 1: bond vectors (v = 0 material, v = 1 spatial)
  logic signed [DIFF_W-1:0] s1_d [2][3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int v = 0; v < 2; v++) begin
        for (int i = 0; i < 3; i++) begin
          s1_d[v][i] <= DIFF_W'(in_f[6*v+i]) - DIFF_W'(in_f[6*v+3+i]);
        end
      end
    end
  end

  // Stage 2: magnitudes and signs
  logic [MAG_W-1:0] s2_mag [2][3];
  logic [1:0][2:0]  s2_neg;
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int v = 0; v < 2; v++) begin
        for (int i = 0; i < 3; i++) begin
          s2_mag[v][i] <= s1_d[v][i][DIFF_W-1] ? MAG_W'(-s1_d[v][i]) : MAG_W'(s1_d[v][i]);
          s2_neg[v][i] <= s1_d[v][i][DIFF_W-1];
        end
      end
    end
  end

  // Stage 3: find the normalizing shift from the largest component
  logic [MAG_W-1:0] s2_or  [2];
  logic [SH_W-1:0]  s2_pos [2];
  always_comb begin
    for (int v = 0; v < 2; v++) begin
      s2_or[v]  = s2_mag[v][0] | s2_mag[v][1] | s2_mag[v][2];
      s2_pos[v] = msb_pos(s2_or[v]);
    end
  end

  logic [MAG_W-1:0] s3_mag [2][3];
  logic [1:0][2:0]  s3_neg;
  logic [1:0]       s3_zero;
  logic [1:0]       s3_rsh;
  logic [SH_W-1:0]  s3_amt [2];
  always_ff @(posedge clk) begin
    if (adv) begin
      s3_neg <= s2_neg;
      for (int v = 0; v < 2; v++) begin
        s3_mag[v]  <= s2_mag[v];
        s3_zero[v] <= (s2_or[v] == '0);
        s3_rsh[v]  <= (s2_pos[v] > NORM_TOP);
        s3_amt[v]  <= (s2_pos[v] > NORM_TOP) ? s2_pos[v] - NORM_TOP : NORM_TOP - s2_pos[v];
      end
    end
  end

  // Stage 4: apply the shift
  side_t s4_side;
  always_ff @(posedge clk) begin
    if (adv) begin
      s4_side.neg  <= s3_neg;
      s4_side.zero <= s3_zero[0] | s3_zero[1];
      for (int v = 0; v < 2; v++) begin
        for (int i = 0; i < 3; i++) begin
          s4_side.nm[v][i] <= s3_rsh[v] ? NORM_BITS'(s3_mag[v][i] >> s3_amt[v])
                                        : NORM_BITS'(s3_mag[v][i] << s3_amt[v]);
        end
      end
    end
  end

  // Stage 5: squares
  logic [2*NORM_BITS-1:0] s5_sq [2][3];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int v = 0; v < 2; v++) begin
        for (int i = 0; i < 3; i++) begin
          s5_sq[v][i] <= s4_side.nm[v][i] * s4_side.nm[v][i];
        end
      end
    end
  end

  // Stage 6: squared lengths
  logic [SUMSQ_W-1:0] s6_sum [2];
  always_ff @(posedge clk) begin
    if (adv) begin
      for (int v = 0; v < 2; v++) begin
        s6_sum[v] <= SUMSQ_W'(s5_sq[v][0]) + SUMSQ_W'(s5_sq[v][1]) + SUMSQ_W'(s5_sq[v][2]);
      end
    end
  end

  // Hold the normalized components alongside the square root
  side_t side_d [0:SIDE_DLY-1];
  always_ff @(posedge clk) begin
    if (adv) begin
      side_d[0] <= s4_side;
      for (int j = 1; j < SIDE_DLY; j++) begin
        side_d[j] <= side_d[j-1];
      end
    end
  end

  // Stages 7..37: lengths; 38..71: unit components
  logic [ROOT_W-1:0] len  [2];
  logic [QUO_W-1:0]  uq   [2][3];
  logic              uovf [2][3];

  for (genvar v = 0; v < 2; v++) begin : g_vec
    bar_isqrt u_isqrt (
      .clk  (clk),
      .en   (adv),
      .rad  (s6_sum[v]),
      .root (len[v])
    );
    for (genvar i = 0; i < 3; i++) begin : g_cmp
      bar_div u_div (
        .clk (clk),
        .en  (adv),
        .dvd (DVD_W'({side_d[SIDE_DLY-1].nm[v][i], {OUT_FRAC_BITS{1'b0}}})),
        .dvs (DVS_W'(len[v])),
        .quo (uq[v][i]),
        .ovf (uovf[v][i])
      );
    end
  end

  // Hold signs and the zero flag alongside the divider
  flg_t flg_d [0:FLG_DLY-1];
  always_ff @(posedge clk) begin
    if (adv) begin
      flg_d[0].neg  <= side_d[SIDE_DLY-1].neg;
      flg_d[0].zero <= side_d[SIDE_DLY-1].zero;
      for (int j = 1; j < FLG_DLY; j++) begin
        flg_d[j] <= flg_d[j-1];
      end
    end
  end

  // Stage 72: signed unit vectors u (v = 0) and v (v = 1)
  logic signed [UNIT_W-1:0] s72_w [2][3];
  logic                     s72_zero;
  always_ff @(posedge clk) begin
    if (adv) begin
      s72_zero <= flg_d[FLG_DLY-1].zero;
      for (int v = 0; v < 2; v++) begin
        for (int i = 0; i < 3; i++) begin
          s72_w[v][i] <= flg_d[FLG_DLY-1].neg[v][i] ? -UNIT_W'(uq[v][i][UNIT_W-2:0])
                                                    : UNIT_W'(uq[v][i][UNIT_W-2:0]);
        end
      end
    end
  end

  // Stage 73: dot and cross products
  logic signed [PROD_W-1:0] s73_dp [3];
  logic signed [PROD_W-1:0] s73_cp [6];
  logic                     s73_zero;
  always_ff @(posedge clk) begin
    if (adv) begin
      s73_zero <= s72_zero;
      for (int i = 0; i < 3; i++) begin
        s73_dp[i] <= s72_w[0][i] * s72_w[1][i];
      end
      s73_cp[0] <= s72_w[0][1] * s72_w[1][2];
      s73_cp[1] <= s72_w[0][2] * s72_w[1][1];
      s73_cp[2] <= s72_w[0][2] * s72_w[1][0];
      s73_cp[3] <= s72_w[0][0] * s72_w[1][2];
      s73_cp[4] <= s72_w[0][0] * s72_w[1][1];
      s73_cp[5] <= s72_w[0][1] * s72_w[1][0];
    end
  end

  // Stage 74: accumulate
  logic signed [ACC_W-1:0] s74_dot;
  logic signed [ACC_W-1:0] s74_cr [3];
  logic                    s74_zero;
  always_ff @(posedge clk) begin
    if (adv) begin
      s74_zero <= s73_zero;
      s74_dot  <= ACC_W'(s73_dp[0]) + ACC_W'(s73_dp[1]) + ACC_W'(s73_dp[2]);
      for (int k = 0; k < 3; k++) begin
        s74_cr[k] <= ACC_W'(s73_cp[2*k]) - ACC_W'(s73_cp[2*k+1]);
      end
    end
  end

  // Stage 75: scale back to Q.F, cosine c and axis a
  logic signed [UNIT_W-1:0] s75_c;
  logic signed [UNIT_W-1:0] s75_a [3];
  logic                     s75_zero;
  always_ff @(posedge clk) begin
    if (adv) begin
      s75_zero <= s74_zero;
      s75_c    <= shr_trunc(s74_dot);
      for (int k = 0; k < 3; k++) begin
        s75_a[k] <= shr_trunc(s74_cr[k]);
      end
    end
  end

  // Stage 76: k = 1 + c and the outer product a*a^T
  logic signed [K_W-1:0]    s76_k;
  logic signed [PROD_W-1:0] s76_aa [6];
  logic signed [UNIT_W-1:0] s76_c;
  logic signed [UNIT_W-1:0] s76_a [3];
  logic                     s76_zero;
  logic                     s76_azero;
  logic                     s76_cpos;
  always_ff @(posedge clk) begin
    if (adv) begin
      s76_zero  <= s75_zero;
      s76_c     <= s75_c;
      s76_a     <= s75_a;
      s76_k     <= K_W'(s75_c) + K_ONE;
      s76_azero <= (s75_a[0] == '0) && (s75_a[1] == '0) && (s75_a[2] == '0);
      s76_cpos  <= (s75_c > 0);
      s76_aa[0] <= s75_a[0] * s75_a[0];
      s76_aa[1] <= s75_a[0] * s75_a[1];
      s76_aa[2] <= s75_a[0] * s75_a[2];
      s76_aa[3] <= s75_a[1] * s75_a[1];
      s76_aa[4] <= s75_a[1] * s75_a[2];
      s76_aa[5] <= s75_a[2] * s75_a[2];
    end
  end

  // Stage 77: dividend magnitudes, status and identity decision
  logic             s76_kle0;
  status_t          s76_st;
  assign s76_kle0 = s76_k[K_W-1] || (s76_k == '0);

  always_comb begin
    priority if (s76_zero) begin
      s76_st = ST_ZERO;
    end else if (s76_azero) begin
      s76_st = s76_cpos ? ST_OK : ST_ANTI;
    end else if (s76_kle0) begin
      s76_st = ST_ANTI;
    end else begin
      s76_st = ST_OK;
    end
  end

  logic [DVD_W-1:0] s77_pmag [6];
  logic [DVS_W-1:0] s77_kd;
  fin_t             s77_fin;
  always_ff @(posedge clk) begin
    if (adv) begin
      s77_kd        <= DVS_W'(s76_k);
      s77_fin.c     <= s76_c;
      s77_fin.st    <= s76_st;
      s77_fin.ident <= s76_zero || s76_azero || s76_kle0;
      for (int k = 0; k < 3; k++) begin
        s77_fin.a[k] <= s76_a[k];
      end
      for (int j = 0; j < 6; j++) begin
        s77_pmag[j]       <= s76_aa[j][PROD_W-1] ? DVD_W'(-s76_aa[j]) : DVD_W'(s76_aa[j]);
        s77_fin.psign[j]  <= s76_aa[j][PROD_W-1];
      end
    end
  end

  // Stages 78..111: a*a^T / k
  logic [QUO_W-1:0] qq  [6];
  logic             qov [6];
  for (genvar j = 0; j < 6; j++) begin : g_aa
    bar_div u_div (
      .clk (clk),
      .en  (adv),
      .dvd (s77_pmag[j]),
      .dvs (s77_kd),
      .quo (qq[j]),
      .ovf (qov[j])
    );
  end

  fin_t fin_d [0:FIN_DLY-1];
  always_ff @(posedge clk) begin
    if (adv) begin
      fin_d[0] <= s77_fin;
      for (int j = 1; j < FIN_DLY; j++) begin
        fin_d[j] <= fin_d[j-1];
      end
    end
  end

  // Stage 112: signed quotients, clamped when too large to matter
  logic signed [E_W-1:0] s112_qs [6];
  fin_t                  s112_fin;
  logic [QUO_W-1:0]      qmag [6];
  always_comb begin
    for (int j = 0; j < 6; j++) begin
      qmag[j] = qov[j] ? '1 : qq[j];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s112_fin <= fin_d[FIN_DLY-1];
      for (int j = 0; j < 6; j++) begin
        s112_qs[j] <= fin_d[FIN_DLY-1].psign[j] ? -E_W'(qmag[j]) : E_W'(qmag[j]);
      end
    end
  end

  // Stage 113: add skew and diagonal terms
  logic signed [E_W-1:0] ae [3];
  logic signed [E_W-1:0] ce;
  always_comb begin
    ce = E_W'($signed(s112_fin.c));
    for (int k = 0; k < 3; k++) begin
      ae[k] = E_W'($signed(s112_fin.a[k]));
    end
  end

  logic signed [E_W-1:0] s113_e [NUM_ROT];
  status_t               s113_st;
  logic                  s113_ident;
  always_ff @(posedge clk) begin
    if (adv) begin
      s113_st    <= s112_fin.st;
      s113_ident <= s112_fin.ident;
      s113_e[0]  <= s112_qs[0] + ce;
      s113_e[1]  <= s112_qs[1] - ae[2];
      s113_e[2]  <= s112_qs[2] + ae[1];
      s113_e[3]  <= s112_qs[1] + ae[2];
      s113_e[4]  <= s112_qs[3] + ce;
      s113_e[5]  <= s112_qs[4] - ae[0];
      s113_e[6]  <= s112_qs[2] - ae[1];
      s113_e[7]  <= s112_qs[4] + ae[0];
      s113_e[8]  <= s112_qs[5] + ce;
    end
  end

  // Stage 114: saturate or force identity into the response register
  logic [OUT_W-1:0] rot [NUM_ROT];
  status_t          out_st;
  always_ff @(posedge clk) begin
    if (adv) begin
      out_st <= s113_st;
      for (int n = 0; n < NUM_ROT; n++) begin
        if (s113_ident) begin
          rot[n] <= DIAG_MASK[n] ? OUT_ONE : '0;
        end else begin
          rot[n] <= sat(s113_e[n]);
        end
      end
    end
  end

  always_comb begin
    for (int n = 0; n < NUM_ROT; n++) begin
      m_axis_tdata[n*OUT_W +: OUT_W] = rot[n];
    end
  end
  assign m_axis_tuser = out_st;

  // Checks
  `BAR_ASSERT_IMP(a_ready_when_empty, !m_axis_tvalid, s_axis_tready, "stall with empty output")
  `BAR_ASSERT_NXT(a_accept_enters, s_axis_tvalid && s_axis_tready, vld[1], "request lost at entry")
  `BAR_ASSERT_IMP(a_flag_identity, m_axis_tvalid && (m_axis_tuser != ST_OK), (m_axis_tdata[31:0] == OUT_ONE) && (m_axis_tdata[63:32] == '0), "flagged response not identity")

endmodule

`default_nettype wire

// File: design/bar_isqrt.sv
// ----------------------------------------------------------------------------
// Pipelined integer square root
// floor(sqrt(rad)), one result bit per register stage, ROOT_W stages.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bar_isqrt (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bar_pkg::SUMSQ_W-1:0] rad,
  output logic [bar_pkg::ROOT_W-1:0]  root
);
  import bar_pkg::*;

  localparam int REM_W = ROOT_W + 2;

  logic [REM_W-1:0]   rem_q  [1:ROOT_W];
  logic [ROOT_W-1:0]  root_q [1:ROOT_W];
  logic [SUMSQ_W-1:0] rad_q  [1:ROOT_W];

  for (genvar j = 1; j <= ROOT_W; j++) begin : g_st
    logic [REM_W-1:0]   rp;
    logic [ROOT_W-1:0]  qp;
    logic [SUMSQ_W-1:0] np;
    logic [REM_W+1:0]   trial;
    logic [REM_W+1:0]   test;
    logic               ge;

    if (j == 1) begin : g_in
      assign rp = '0;
      assign qp = '0;
      assign np = rad;
    end else begin : g_mid
      assign rp = rem_q[j-1];
      assign qp = root_q[j-1];
      assign np = rad_q[j-1];
    end

    // Bring down the next pair of radicand bits and try 4*root+1
    always_comb begin
      trial = {rp, np[2*(ROOT_W-j)+1 -: 2]};
      test  = (REM_W+2)'({qp, 2'b01});
      ge    = (trial >= test);
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j]  <= ge ? REM_W'(trial - test) : REM_W'(trial);
        root_q[j] <= {qp[ROOT_W-2:0], ge};
        rad_q[j]  <= np;
      end
    end
  end

  assign root = root_q[ROOT_W];

endmodule

`default_nettype wire

// File: design/bar_div.sv
// ----------------------------------------------------------------------------
// Pipelined unsigned divider
// Restoring division, one quotient bit per register stage, QUO_W stages.
// Flags a quotient that does not fit in QUO_W bits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module bar_div (
  input  logic                      clk,
  input  logic                      en,
  input  logic [bar_pkg::DVD_W-1:0] dvd,
  input  logic [bar_pkg::DVS_W-1:0] dvs,
  output logic [bar_pkg::QUO_W-1:0] quo,
  output logic                      ovf
);
  import bar_pkg::*;

  logic [DVS_W-1:0] rem_q [1:QUO_W];
  logic [QUO_W-1:0] quo_q [1:QUO_W];
  logic [DVD_W-1:0] dvd_q [1:QUO_W];
  logic [DVS_W-1:0] dvs_q [1:QUO_W];
  logic             ovf_q [1:QUO_W];

  for (genvar j = 1; j <= QUO_W; j++) begin : g_st
    logic [DVS_W-1:0] rp;
    logic [QUO_W-1:0] qp;
    logic [DVD_W-1:0] dp;
    logic [DVS_W-1:0] vp;
    logic             op;
    logic [DVS_W:0]   trial;
    logic             ge;

    if (j == 1) begin : g_in
      // Upper dividend bits start the remainder; overflow if they reach dvs
      assign rp = DVS_W'(dvd[DVD_W-1:QUO_W]);
      assign qp = '0;
      assign dp = dvd;
      assign vp = dvs;
      assign op = (DVS_W'(dvd[DVD_W-1:QUO_W]) >= dvs);
    end else begin : g_mid
      assign rp = rem_q[j-1];
      assign qp = quo_q[j-1];
      assign dp = dvd_q[j-1];
      assign vp = dvs_q[j-1];
      assign op = ovf_q[j-1];
    end

    // Shift in one dividend bit, subtract when it fits
    always_comb begin
      trial = {rp, dp[QUO_W-j]};
      ge    = (trial >= {1'b0, vp});
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_q[j] <= ge ? DVS_W'(trial - {1'b0, vp}) : DVS_W'(trial);
        quo_q[j] <= {qp[QUO_W-2:0], ge};
        dvd_q[j] <= dp;
        dvs_q[j] <= vp;
        ovf_q[j] <= op;
      end
    end
  end

  assign quo = quo_q[QUO_W];
  assign ovf = ovf_q[QUO_W];

endmodule

`default_nettype wire

// File: sim/bond_alignment_rotation_checker.sv
// ----------------------------------------------------------------------------
// Bond alignment rotation checker
// Watches both stream channels, predicts each rotation from the accepted
// request and compares it field by field with the response.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module bond_alignment_rotation_checker (
  input  logic                                               clk,
  input  logic                                               rst,
  input  logic [bar_pkg::NUM_IN*bar_pkg::COORD_WIDTH-1:0]    s_axis_tdata,
  input  logic                                               s_axis_tvalid,
  input  logic                                               s_axis_tready,
  input  logic [bar_pkg::NUM_ROT*bar_pkg::OUT_W-1:0]         m_axis_tdata,
  input  logic [1:0]                                         m_axis_tuser,
  input  logic                                               m_axis_tvalid,
  input  logic                                               m_axis_tready,
  output int                                                 errors,
  output int                                                 pending
);
  import bar_pkg::*;

  typedef longint vec3_t [3];
  typedef struct {
    logic [OUT_W-1:0] rot [NUM_ROT];
    status_t          st;
  } rotation_t;

  rotation_t rot_q [$];

  task automatic report(input string what, input longint got, input longint want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    errors++;
  endtask

  // Append one predicted rotation at the tail of the queue
  task automatic queue_rotation(input rotation_t r);
    rot_q.insert(rot_q.size(), r);
  endtask

  // Truncating shift that keeps the sign
  function automatic longint shr_trunc(input longint x, input int s);
    longint unsigned m;
    m = (x < 0) ? -x : x;
    m = m >> s;
    return (x < 0) ? -longint'(m) : longint'(m);
  endfunction

  function automatic longint unsigned int_sqrt(input longint unsigned n);
    longint unsigned root, b;
    root = 0;
    b = 64'd1 << 62;
    while (b > n) b = b >> 2;
    while (b != 0) begin
      if (n >= root + b) begin
        n = n - (root + b);
        root = (root >> 1) + b;
      end else begin
        root = root >> 1;
      end
      b = b >> 2;
    end
    return root;
  endfunction

  // Scale a bond vector to a unit direction in Q.30; zero vector returns 0
  function automatic bit unit_dir(input vec3_t d, output vec3_t u);
    longint unsigned mag [3];
    longint unsigned m, sum, len;
    m = 0;
    sum = 0;
    for (int i = 0; i < 3; i++) begin
      mag[i] = (d[i] < 0) ? -d[i] : d[i];
      if (mag[i] > m) m = mag[i];
    end
    if (m == 0) return 0;
    while (m >= (64'd1 << NORM_BITS)) begin
      m = m >> 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] >> 1;
    end
    while (m < (64'd1 << (NORM_BITS - 1))) begin
      m = m << 1;
      for (int i = 0; i < 3; i++) mag[i] = mag[i] << 1;
    end
    for (int i = 0; i < 3; i++) sum += mag[i] * mag[i];
    len = int_sqrt(sum);
    for (int i = 0; i < 3; i++) begin
      u[i] = longint'((mag[i] << OUT_FRAC_BITS) / len);
      if (d[i] < 0) u[i] = -u[i];
    end
    return 1;
  endfunction

  function automatic logic [OUT_W-1:0] sat32(input longint x);
    if (x > 64'sd2147483647) x = 64'sd2147483647;
    if (x < -64'sd2147483648) x = -64'sd2147483648;
    return x[OUT_W-1:0];
  endfunction

  function automatic rotation_t identity_rot(input status_t st);
    rotation_t r;
    for (int i = 0; i < NUM_ROT; i++) r.rot[i] = DIAG_MASK[i] ? sat32(64'sd1 << OUT_FRAC_BITS) : '0;
    r.st = st;
    return r;
  endfunction

  function automatic rotation_t align_rotation(
    input logic [NUM_IN*COORD_WIDTH-1:0] pos
  );
    vec3_t dm, ds, u, v, a;
    longint c, k, e;
    longint skew [3][3];
    rotation_t r;
    for (int i = 0; i < 3; i++) begin
      dm[i] = longint'($signed(pos[i*32 +: 32])) - longint'($signed(pos[(3+i)*32 +: 32]));
      ds[i] = longint'($signed(pos[(6+i)*32 +: 32])) - longint'($signed(pos[(9+i)*32 +: 32]));
    end
    if (!unit_dir(dm, u)) return identity_rot(ST_ZERO);
    if (!unit_dir(ds, v)) return identity_rot(ST_ZERO);
    c = shr_trunc(u[0]*v[0] + u[1]*v[1] + u[2]*v[2], OUT_FRAC_BITS);
    a[0] = shr_trunc(u[1]*v[2] - u[2]*v[1], OUT_FRAC_BITS);
    a[1] = shr_trunc(u[2]*v[0] - u[0]*v[2], OUT_FRAC_BITS);
    a[2] = shr_trunc(u[0]*v[1] - u[1]*v[0], OUT_FRAC_BITS);
    k = (64'sd1 << OUT_FRAC_BITS) + c;
    if (a[0] == 0 && a[1] == 0 && a[2] == 0) return identity_rot(c > 0 ? ST_OK : ST_ANTI);
    if (k <= 0) return identity_rot(ST_ANTI);
    skew[0][0] = 0;     skew[0][1] = -a[2]; skew[0][2] = a[1];
    skew[1][0] = a[2];  skew[1][1] = 0;     skew[1][2] = -a[0];
    skew[2][0] = -a[1]; skew[2][1] = a[0];  skew[2][2] = 0;
    for (int rr = 0; rr < 3; rr++)
      for (int q = 0; q < 3; q++) begin
        e = skew[rr][q] + (a[rr] * a[q]) / k;
        if (rr == q) e += c;
        r.rot[rr*3 + q] = sat32(e);
      end
    r.st = ST_OK;
    return r;
  endfunction

  // Predict on every accepted request, compare on every accepted response
  always @(posedge clk) begin
    rotation_t exp_rot;
    if (rst) begin
      rot_q.delete();
      errors = 0;
      pending <= 0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) queue_rotation(align_rotation(s_axis_tdata));
      if (m_axis_tvalid && m_axis_tready) begin
        if (rot_q.size() == 0) begin
          report("unexpected response", m_axis_tuser, 0);
        end else begin
          exp_rot = rot_q.pop_front();
          for (int i = 0; i < NUM_ROT; i++)
            if (m_axis_tdata[i*OUT_W +: OUT_W] !== exp_rot.rot[i])
              report($sformatf("rot_%0d%0d", i / 3, i % 3),
                     m_axis_tdata[i*OUT_W +: OUT_W], exp_rot.rot[i]);
          if (m_axis_tuser !== exp_rot.st) report("status", m_axis_tuser, exp_rot.st);
        end
      end
      pending <= rot_q.size();
    end
  end

endmodule

// File: sim/tb_bond_alignment_rotation_matrix.sv
// ----------------------------------------------------------------------------
// Bond alignment rotation testbench
// Streams directed and random bonds through the pipeline with random gaps
// and back-pressure; the checker predicts and compares every rotation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_bond_alignment_rotation_matrix;
  import bar_pkg::*;

  localparam int LATENCY   = 114;
  localparam int N_RANDOM  = 690;
  localparam int MAX_CYCLE = 1000000;

  logic                              clk;
  logic                              rst;
  logic [NUM_IN*COORD_WIDTH-1:0]     s_axis_tdata;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [NUM_ROT*OUT_W-1:0]          m_axis_tdata;
  logic [1:0]                        m_axis_tuser;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  int                                errors;
  int                                pending;
  int                                cycle = 0;
  bit                                hold_req;

  bond_alignment_rotation_matrix u_dut (
    .clk(clk), .rst(rst),
    .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready)
  );

  bond_alignment_rotation_checker u_checker (
    .clk(clk), .rst(rst),
    .s_axis_tdata(s_axis_tdata), .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .errors(errors), .pending(pending)
  );

  always begin
    clk = 1'b1; #10;
    clk = 1'b0; #10;
  end

  // Gap length: mostly short, a few long
  function automatic int gap_len();
    int p;
    p = $urandom_range(99);
    if (p < 45) return 0;
    if (p < 90) return $urandom_range(3, 1);
    return $urandom_range(40, 8);
  endfunction

  // Timeout
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (cycle >= MAX_CYCLE) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Response side: random stalls, a long hold-off on request
  initial begin
    int hold;
    m_axis_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_req) begin
        hold = 400;
        while (hold > 0) begin
          m_axis_tready <= 1'b0;
          @(posedge clk);
          hold--;
        end
      end
      hold = gap_len();
      if (hold == 0 || $urandom_range(3) == 0) begin
        m_axis_tready <= 1'b1;
        @(posedge clk);
      end else begin
        repeat (hold) begin
          m_axis_tready <= 1'b0;
          @(posedge clk);
        end
      end
    end
  end

  int  bond_pos [NUM_IN];
  bit  no_gaps;

  // Offer one bond, hold it until taken, then idle for a random gap unless gaps are off
  task automatic send_bond();
    int g;
    for (int i = 0; i < NUM_IN; i++) s_axis_tdata[i*32 +: 32] <= bond_pos[i];
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    g = no_gaps ? 0 : gap_len();
    if (g > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // Build positions i = j + bond for both configurations
  task automatic set_bonds(input int mx, my, mz, sx, sy, sz);
    int mv [3];
    int sv [3];
    mv = '{mx, my, mz};
    sv = '{sx, sy, sz};
    for (int i = 0; i < 3; i++) begin
      bond_pos[3+i] = $urandom_range(2000000) - 1000000;
      bond_pos[i]   = bond_pos[3+i] + mv[i];
      bond_pos[9+i] = $urandom_range(2000000) - 1000000;
      bond_pos[6+i] = bond_pos[9+i] + sv[i];
    end
  endtask

  function automatic int small_coord();
    return int'($urandom_range(1 << 21)) - (1 << 20);
  endfunction

  initial begin
    int mx, my, mz, kind;
    rst = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    hold_req = 1'b0;
    no_gaps = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: zero bonds, parallel, antiparallel, perpendicular, extremes
    set_bonds(0, 0, 0, 0, 0, 0); send_bond();
    set_bonds(0, 0, 0, 65536, 0, 0); send_bond();
    set_bonds(0, 65536, 0, 0, 0, 0); send_bond();
    set_bonds(65536, 0, 0, 3 << 16, 0, 0); send_bond();
    set_bonds(12345, -777, 4096, 24690, -1554, 8192); send_bond();
    set_bonds(65536, 0, 0, -65536, 0, 0); send_bond();
    set_bonds(1000, 2000, -3000, -1000, -2000, 3000); send_bond();
    set_bonds(1 << 20, 0, 0, -(1 << 20), 3, 0); send_bond();
    set_bonds(1 << 20, 0, 0, -(1 << 20), 1 << 12, -(1 << 11)); send_bond();
    set_bonds(1 << 20, 0, 0, 1 << 20, 1, 0); send_bond();
    set_bonds(65536, 0, 0, 0, 65536, 0); send_bond();
    set_bonds(0, 0, 65536, 65536, 0, 0); send_bond();
    set_bonds(1, 1, 1, -1, 1, -1); send_bond();
    bond_pos = '{default: 32'h7fffffff};
    for (int i = 3; i < 6; i++) bond_pos[i] = 32'h80000000;
    for (int i = 6; i < 9; i++) bond_pos[i] = 32'h80000000;
    send_bond();
    bond_pos = '{default: 32'h80000000};
    for (int i = 3; i < 6; i++) bond_pos[i] = 32'h7fffffff;
    bond_pos[9] = 32'h7fffffff;
    send_bond();
    bond_pos = '{default: 32'hffffffff};
    bond_pos[0] = 32'h00000000;
    bond_pos[8] = 32'h7fffffff;
    send_bond();
    bond_pos[3] = 32'h55555555; bond_pos[10] = 32'haaaaaaaa;
    send_bond();

    // Pause until every response is back
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);

    for (int n = 0; n < N_RANDOM; n++) begin
      // Mid-run: receiver holds off while requests keep coming
      if (n == N_RANDOM / 2) begin
        hold_req <= 1'b1;
        no_gaps <= 1'b1;
      end
      if (n == N_RANDOM / 2 + 200) begin
        hold_req <= 1'b0;
        no_gaps <= 1'b0;
      end
      kind = $urandom_range(99);
      mx = small_coord(); my = small_coord(); mz = small_coord();
      if (kind < 40) begin
        foreach (bond_pos[i]) bond_pos[i] = $urandom;
      end else if (kind < 70) begin
        set_bonds(mx, my, mz, small_coord(), small_coord(), small_coord());
      end else if (kind < 85) begin
        set_bonds(mx, my, mz, -mx + $urandom_range(8) - 4, -my + $urandom_range(8) - 4,
                  -mz + $urandom_range(8) - 4);
      end else if (kind < 95) begin
        set_bonds(mx, my, mz, mx <<< (kind % 4), my <<< (kind % 4), mz <<< (kind % 4));
      end else begin
        set_bonds(mx, my, mz, 0, 0, 0);
        if (kind[0]) for (int i = 0; i < 3; i++) begin
          bond_pos[i] = bond_pos[3+i];
          bond_pos[6+i] = $urandom;
        end
      end
      send_bond();
    end
    s_axis_tvalid <= 1'b0;

    // Drain and settle
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 20) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: sim.f
+incdir+design
design/bar_pkg.sv
design/bar_isqrt.sv
design/bar_div.sv
design/bond_alignment_rotation_matrix.sv
sim/bond_alignment_rotation_checker.sv
sim/tb_bond_alignment_rotation_matrix.sv
